@@ rtl/core/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsc_pkg
// shared codes, constants and item types of the triggered scope capture
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_TAKE   = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;

    localparam logic [1:0] BANK_0 = 2'd0;
    localparam logic [1:0] BANK_1 = 2'd1;
    localparam logic [1:0] BANK_2 = 2'd2;

    localparam int X_ORIGIN   = -120;
    localparam int CORNER_FAR = 130;

    localparam logic [3:0] SCALE_SHIFT_RESET = 4'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one accepted point request, as it leaves the front end
    typedef struct packed {
        logic              is_corner;
        logic              unwritten;
        logic              last;
        logic signed [8:0] x;
        logic signed [15:0] corner_y;
    } point_tok_t;

    // queue entry: request plus the raw sample read for it
    typedef struct packed {
        point_tok_t         tok;
        logic signed [15:0] raw;
    } point_entry_t;

    function automatic logic signed [8:0] corner_x(input logic [1:0] c);
        logic signed [8:0] v;
        case (c)
            2'd0, 2'd1: v = 9'(CORNER_FAR);
            default:    v = 9'(-CORNER_FAR);
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] corner_y(input logic [1:0] c);
        logic signed [15:0] v;
        case (c)
            2'd1, 2'd2: v = 16'(-CORNER_FAR);
            default:    v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/tsc_ram.sv @@
// ----------------------------------------------------------------------------
// tsc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module tsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 720
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/tsc_front.sv @@
// ----------------------------------------------------------------------------
// tsc_front
// accepts items, runs trigger and bank rotation, issues sample ram accesses
// ----------------------------------------------------------------------------
module tsc_front #(
    parameter int FRAME_LENGTH = 240,
    parameter int DECIMATION   = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic signed [15:0]                  sample,
    input  logic [6:0]                          point_index,
    input  logic [tsc_pkg::QCNT_W-1:0]          queue_count,
    output logic                                ram_wr_en,
    output logic [$clog2(3*FRAME_LENGTH)-1:0]   ram_wr_addr,
    output logic [15:0]                         ram_wr_data,
    output logic                                ram_rd_en,
    output logic [$clog2(3*FRAME_LENGTH)-1:0]   ram_rd_addr,
    output logic                                tok_valid,
    output tsc_pkg::point_tok_t                 tok
);

    localparam int TRACE_POINTS = 1 + (FRAME_LENGTH - 1 + DECIMATION - 1) / DECIMATION;
    localparam int POS_W  = $clog2(FRAME_LENGTH + 1);
    localparam int IDX_W  = $clog2(FRAME_LENGTH);
    localparam int ADDR_W = $clog2(3 * FRAME_LENGTH);
    localparam int SI_W   = 8 + $clog2(DECIMATION);

    logic [1:0]          fill_reg, fill_next;
    logic [1:0]          spare_reg, spare_next;
    logic [1:0]          show_reg, show_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic signed [15:0]  prev_reg;
    logic [POS_W-1:0]    hw_reg [3];
    logic [POS_W-1:0]    hw_next [3];
    logic                tok_valid_reg, tok_valid_next;
    tsc_pkg::point_tok_t tok_reg, tok_next;

    logic                accept;
    logic                do_write;
    logic [POS_W-1:0]    pos_inc;
    logic [SI_W-1:0]     si_full;
    logic [IDX_W-1:0]    si;
    logic                in_trace;
    logic                in_corner;
    logic [1:0]          corner_sel;
    logic [ADDR_W-1:0]   fill_base;
    logic [ADDR_W-1:0]   show_base;

    function automatic logic [ADDR_W-1:0] bank_base(input logic [1:0] b);
        logic [ADDR_W-1:0] v;
        unique case (b)
            tsc_pkg::BANK_0: v = '0;
            tsc_pkg::BANK_1: v = ADDR_W'(FRAME_LENGTH);
            default:         v = ADDR_W'(2 * FRAME_LENGTH);
        endcase
        return v;
    endfunction

    assign in_ready = (int'(queue_count) + int'(tok_valid_reg)) < tsc_pkg::QUEUE_DEPTH;
    assign accept   = in_valid && in_ready;

    assign fill_base = bank_base(fill_reg);
    assign show_base = bank_base(show_reg);
    assign pos_inc   = pos_reg + POS_W'(1);

    assign si_full = (point_index == 7'd0) ? '0 :
                     SI_W'(1) + SI_W'(point_index - 7'd1) * SI_W'(DECIMATION);
    assign si      = (int'(si_full) >= FRAME_LENGTH) ? IDX_W'(FRAME_LENGTH - 1)
                                                     : IDX_W'(si_full);

    assign in_trace   = int'(point_index) < TRACE_POINTS;
    assign in_corner  = !in_trace && (int'(point_index) < TRACE_POINTS + 4);
    assign corner_sel = 2'(int'(point_index) - TRACE_POINTS);

    assign do_write = accept && (kind == tsc_pkg::KIND_SAMPLE)
                      && !((pos_reg == '0) && !((sample > 16'sd0) && (prev_reg <= 16'sd0)))
                      && (int'(pos_reg) < FRAME_LENGTH);

    assign ram_wr_en   = do_write;
    assign ram_wr_addr = fill_base + ADDR_W'(pos_reg[IDX_W-1:0]);
    assign ram_wr_data = sample;
    assign ram_rd_en   = accept && (kind == tsc_pkg::KIND_POINT) && in_trace;
    assign ram_rd_addr = show_base + ADDR_W'(si);

    always_comb
    begin
        fill_next      = fill_reg;
        spare_next     = spare_reg;
        show_next      = show_reg;
        pos_next       = pos_reg;
        hw_next        = hw_reg;
        tok_valid_next = tok_valid_reg;
        tok_next       = tok_reg;
        if (accept)
        begin
            tok_valid_next = 1'b0;
            case (kind)
                tsc_pkg::KIND_SAMPLE:
                begin
                    if (!((pos_reg == '0) && !((sample > 16'sd0) && (prev_reg <= 16'sd0))))
                    begin
                        if (int'(pos_reg) >= FRAME_LENGTH)
                        begin
                            fill_next  = spare_reg;
                            spare_next = fill_reg;
                            pos_next   = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                            if (pos_inc > hw_reg[fill_reg])
                            begin
                                hw_next[fill_reg] = pos_inc;
                            end
                        end
                    end
                end
                tsc_pkg::KIND_TAKE:
                begin
                    show_next  = spare_reg;
                    spare_next = show_reg;
                end
                tsc_pkg::KIND_POINT:
                begin
                    tok_valid_next     = in_trace || in_corner;
                    tok_next.is_corner = !in_trace;
                    tok_next.unwritten = POS_W'(si) >= hw_reg[show_reg];
                    tok_next.last      = in_corner && (corner_sel == 2'd3);
                    tok_next.x         = in_trace
                        ? 9'(tsc_pkg::X_ORIGIN + DECIMATION * int'(point_index))
                        : tsc_pkg::corner_x(corner_sel);
                    tok_next.corner_y  = tsc_pkg::corner_y(corner_sel);
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            tok_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= tsc_pkg::BANK_0;
            spare_reg     <= tsc_pkg::BANK_1;
            show_reg      <= tsc_pkg::BANK_2;
            pos_reg       <= '0;
            prev_reg      <= '0;
            hw_reg        <= '{default: '0};
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            spare_reg     <= spare_next;
            show_reg      <= show_next;
            pos_reg       <= pos_next;
            hw_reg        <= hw_next;
            tok_valid_reg <= tok_valid_next;
            if (accept && (kind == tsc_pkg::KIND_SAMPLE))
            begin
                prev_reg <= sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

@@ rtl/core/tsc_queue.sv @@
// ----------------------------------------------------------------------------
// tsc_queue
// short fifo of point requests between front end and output stage
// ----------------------------------------------------------------------------
module tsc_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  tsc_pkg::point_entry_t      push_entry,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output tsc_pkg::point_entry_t      pop_entry,
    output logic [tsc_pkg::QCNT_W-1:0] count
);

    tsc_pkg::point_entry_t         entry_reg [tsc_pkg::QUEUE_DEPTH];
    logic [tsc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tsc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tsc_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = count_reg != '0;
    assign pop_entry = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tsc_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + tsc_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tsc_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tsc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/tsc_back.sv @@
// ----------------------------------------------------------------------------
// tsc_back
// output stage: scales trace samples, zeroes unwritten ones, picks corner values, holds the result
// ----------------------------------------------------------------------------
module tsc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [3:0]            scale_shift,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  tsc_pkg::point_entry_t q_entry,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [8:0]     out_x,
    output logic signed [15:0]    out_y,
    output logic                  out_last
);

    logic               valid_reg;
    logic signed [8:0]  x_reg;
    logic signed [15:0] y_reg;
    logic               last_reg;
    logic signed [15:0] y_next;
    logic               load;

    assign q_ready = !valid_reg || out_ready;
    assign load    = q_valid && q_ready;

    always_comb
    begin
        if (q_entry.tok.is_corner)
        begin
            y_next = q_entry.tok.corner_y;
        end
        else if (q_entry.tok.unwritten)
        begin
            y_next = '0;
        end
        else
        begin
            y_next = q_entry.raw >>> scale_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_ready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= q_entry.tok.x;
            y_reg    <= y_next;
            last_reg <= q_entry.tok.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_last  = last_reg;

endmodule

@@ rtl/core/triggered_scope_capture.sv @@
// ----------------------------------------------------------------------------
// triggered_scope_capture
// zero crossing triggered capture into three rotating sample banks
// ----------------------------------------------------------------------------
//  channel  direction  transfer carries
//  s_*      in         kind, sample, point index
//  m_*      out        point x, point y, last point flag
//  cfg_*    in         scale shift
//
//  one item per cycle on s_* while s_tready is high; the single sample ram
//  port pair sets this; a point result is registered in front, queue and back
//  banks read as zero until written: per bank high-water marks, no clear pass
//  a stalled m_* fills a four entry queue, then s_tready drops
// ----------------------------------------------------------------------------
module triggered_scope_capture #(
    parameter int FRAME_LENGTH = 240,
    parameter int DECIMATION   = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sample[15:0], point_index[22:16], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // point_x[8:0], point_y[24:9], zero pad
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int ADDR_W = $clog2(3 * FRAME_LENGTH);

    logic [3:0]                    scale_shift_reg;
    logic [tsc_pkg::QCNT_W-1:0]    queue_count;
    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             ram_wr_addr;
    logic [15:0]                   ram_wr_data;
    logic                          ram_rd_en;
    logic [ADDR_W-1:0]             ram_rd_addr;
    logic [15:0]                   ram_rd_data;
    logic                          tok_valid;
    tsc_pkg::point_tok_t           tok;
    tsc_pkg::point_entry_t         push_entry;
    logic                          q_valid;
    logic                          q_ready;
    tsc_pkg::point_entry_t         q_entry;
    logic signed [8:0]             point_x;
    logic signed [15:0]            point_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_shift_reg <= tsc_pkg::SCALE_SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_shift_reg <= cfg_data;
        end
    end

    tsc_front #(
        .FRAME_LENGTH (FRAME_LENGTH),
        .DECIMATION   (DECIMATION)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .kind        (s_tuser),
        .sample      (s_tdata[15:0]),
        .point_index (s_tdata[22:16]),
        .queue_count (queue_count),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .tok_valid   (tok_valid),
        .tok         (tok)
    );

    tsc_ram #(
        .WIDTH (16),
        .DEPTH (3 * FRAME_LENGTH)
    ) u_banks (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign push_entry.tok = tok;
    assign push_entry.raw = ram_rd_data;

    tsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tok_valid),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_entry  (q_entry),
        .count      (queue_count)
    );

    tsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .scale_shift (scale_shift_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_entry     (q_entry),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (point_x),
        .out_y       (point_y),
        .out_last    (m_tlast)
    );

    assign m_tdata = {7'd0, point_y, point_x};

endmodule

@@ sim/scope_point_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scope_point_checker
// watches the sample, point and scale channels of the triggered scope
// capture, keeps its own copy of the three banks, the trigger and the
// scale, predicts every polyline point on its way in and compares each
// point transfer with the oldest prediction
// ----------------------------------------------------------------------------
module scope_point_checker #(
    parameter int FRAME_LENGTH = 240,
    parameter int DECIMATION   = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // sample[15:0], point_index[22:16], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // point_x[8:0], point_y[24:9], zero pad
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          points_outstanding
);

    localparam int TRACE_POINTS = 1 + (FRAME_LENGTH - 1 + DECIMATION - 1) / DECIMATION;
    localparam int LAST_CORNER  = 3;

    typedef struct packed {
        logic signed [8:0]  x;
        logic signed [15:0] y;
        logic               last;
    } scope_point_t;

    logic signed [15:0] bank_mem [3][FRAME_LENGTH];
    logic [1:0]         fill_bank;
    logic [1:0]         spare_bank;
    logic [1:0]         show_bank;
    int                 fill_pos;
    logic signed [15:0] prior_sample;
    logic [3:0]         scale_shift;
    scope_point_t       due_points [$];

    // trigger on a rising zero crossing, then fill until full; the sample
    // after a full bank is dropped and swaps fill and spare
    function automatic void capture_sample(input logic signed [15:0] v);
        logic signed [15:0] earlier;
        logic [1:0]         t;
        earlier = prior_sample;
        prior_sample = v;
        if (fill_pos == 0 && !(v > 0 && earlier <= 0))
            return;
        if (fill_pos >= FRAME_LENGTH)
        begin
            t = fill_bank;
            fill_bank = spare_bank;
            spare_bank = t;
            fill_pos = 0;
        end
        else
        begin
            bank_mem[fill_bank][fill_pos] = v;
            fill_pos++;
        end
    endfunction

    function automatic scope_point_t plot_point(input int p);
        scope_point_t pt;
        int           si;
        int           c;
        pt.last = 1'b0;
        if (p < TRACE_POINTS)
        begin
            si = (p == 0) ? 0 : 1 + (p - 1) * DECIMATION;
            if (si >= FRAME_LENGTH)
                si = FRAME_LENGTH - 1;
            pt.x = 9'(tsc_pkg::X_ORIGIN + DECIMATION * p);
            pt.y = bank_mem[show_bank][si] >>> scale_shift;
        end
        else
        begin
            // closing frame corners, clockwise from the right edge
            c = p - TRACE_POINTS;
            pt.x = (c <= 1) ? 9'(tsc_pkg::CORNER_FAR) : 9'(-tsc_pkg::CORNER_FAR);
            pt.y = (c == 0 || c == LAST_CORNER) ? 16'sd0 : 16'(-tsc_pkg::CORNER_FAR);
            pt.last = (c == LAST_CORNER);
        end
        return pt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        scope_point_t got;
        scope_point_t want;
        logic [1:0]   t;
        int           p;
        if (!rst_n)
        begin
            for (int b = 0; b < 3; b++)
                for (int i = 0; i < FRAME_LENGTH; i++)
                    bank_mem[b][i] = '0;
            fill_bank = tsc_pkg::BANK_0;
            spare_bank = tsc_pkg::BANK_1;
            show_bank = tsc_pkg::BANK_2;
            fill_pos = 0;
            prior_sample = '0;
            scale_shift = tsc_pkg::SCALE_SHIFT_RESET;
            due_points.delete();
            fail_count = 0;
            points_outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                scale_shift = cfg_data;

            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[8:0];
                got.y = m_tdata[24:9];
                got.last = m_tlast;
                if (due_points.size() == 0)
                begin
                    $error("point transfer with nothing expected: x %0d y %0d last %0b",
                           got.x, got.y, got.last);
                    fail_count++;
                end
                else
                begin
                    want = due_points.pop_front();
                    if (got.x !== want.x)
                    begin
                        $error("point_x expected %0d actual %0d", want.x, got.x);
                        fail_count++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("point_y expected %0d actual %0d", want.y, got.y);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("final_point expected %0b actual %0b", want.last, got.last);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    tsc_pkg::KIND_SAMPLE:
                        capture_sample($signed(s_tdata[15:0]));
                    tsc_pkg::KIND_TAKE:
                    begin
                        t = show_bank;
                        show_bank = spare_bank;
                        spare_bank = t;
                    end
                    tsc_pkg::KIND_POINT:
                    begin
                        p = s_tdata[22:16];
                        if (p < TRACE_POINTS + 4)
                            due_points.push_back(plot_point(p));
                    end
                    default:
                        ;
                endcase
            end

            points_outstanding <= due_points.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// regression for the triggered scope capture: directed corner items, then
// whole captures (trigger, full bank, swap, take, point reads) with random
// content and noise, under bursty input, a stalling output and several
// scale settings; checking lives in scope_point_checker
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         ITEM_TARGET    = 1550;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         POINT_COUNT    = 125;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;

    localparam logic [1:0] STALL_NONE  = 2'd0;
    localparam logic [1:0] STALL_COIN  = 2'd1;
    localparam logic [1:0] STALL_HEAVY = 2'd2;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // sample[15:0], point_index[22:16], zero pad
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // point_x[8:0], point_y[24:9], zero pad
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    int          fail_count;
    int          points_outstanding;
    int          items_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    logic [15:0] stall_tick = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    triggered_scope_capture dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    scope_point_checker checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tlast            (m_tlast),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .points_outstanding (points_outstanding)
    );

    // output backpressure cycles through its own modes
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[10:9])
            STALL_NONE:  m_tready <= 1'b1;
            STALL_COIN:  m_tready <= 1'($urandom_range(0, 1));
            STALL_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= stall_tick[3];
        endcase
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("triggered_scope_capture regression: fail");
        $finish;
    end

    task automatic send_item(input logic [1:0] kind, input logic [15:0] sample,
                             input logic [6:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, idx, sample};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // scale changes only once every point has drained
    task automatic write_scale(input logic [3:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (points_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // quiet lead-in, trigger, a full bank plus the swapping sample, take, reads
    task automatic run_frame();
        int lead;
        int j;
        lead = $urandom_range(0, 4);
        repeat (lead)
            send_item(tsc_pkg::KIND_SAMPLE, 16'(-$urandom_range(0, 32768)), 7'($urandom));
        send_item(tsc_pkg::KIND_SAMPLE, 16'(-$urandom_range(0, 32768)), 7'($urandom));
        send_item(tsc_pkg::KIND_SAMPLE, 16'($urandom_range(1, 32767)), 7'($urandom));
        for (j = 0; j < 240; j++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(tsc_pkg::KIND_POINT, 16'($urandom), 7'($urandom));
            if ($urandom_range(0, 63) == 0)
                send_item(tsc_pkg::KIND_TAKE, 16'($urandom), 7'($urandom));
            send_item(tsc_pkg::KIND_SAMPLE, 16'($urandom), 7'($urandom));
        end
        send_item(tsc_pkg::KIND_TAKE, 16'($urandom), 7'($urandom));
        if ($urandom_range(0, 2) == 0)
        begin
            for (j = 0; j < POINT_COUNT; j++)
                send_item(tsc_pkg::KIND_POINT, 16'($urandom), 7'(j));
        end
        else
        begin
            repeat (40)
                send_item(tsc_pkg::KIND_POINT, 16'($urandom), 7'($urandom));
        end
    endtask

    initial
    begin
        int         phase;
        logic [3:0] shift_pick;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= tsc_pkg::KIND_SAMPLE;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty banks, trace ends, corners, out of range, unused kind
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd0);
        send_item(tsc_pkg::KIND_POINT, 16'hffff, 7'd120);
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd121);
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd122);
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd123);
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd124);
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd125);
        send_item(tsc_pkg::KIND_POINT, 16'hffff, 7'd127);
        send_item(KIND_UNUSED, 16'hffff, 7'd127);
        send_item(KIND_UNUSED, 16'h0001, 7'd0);
        // zero is not a crossing, minimum then one is
        send_item(tsc_pkg::KIND_SAMPLE, 16'h0000, 7'd0);
        send_item(tsc_pkg::KIND_SAMPLE, 16'h8000, 7'd0);
        send_item(tsc_pkg::KIND_SAMPLE, 16'h0001, 7'd127);
        send_item(tsc_pkg::KIND_SAMPLE, 16'h7fff, 7'd0);
        send_item(tsc_pkg::KIND_SAMPLE, 16'hffff, 7'd0);
        send_item(tsc_pkg::KIND_SAMPLE, 16'h0000, 7'd0);
        send_item(tsc_pkg::KIND_TAKE, 16'h0000, 7'd0);
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd0);
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd1);
        send_item(tsc_pkg::KIND_TAKE, 16'hffff, 7'd127);
        send_item(tsc_pkg::KIND_POINT, 16'h0000, 7'd124);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase % 6)
                0:       shift_pick = 4'd0;
                1:       shift_pick = 4'd15;
                2:       shift_pick = 4'd1;
                4:       shift_pick = 4'd14;
                default: shift_pick = 4'($urandom);
            endcase
            write_scale(shift_pick);
            run_frame();
            repeat (15)
                send_item(2'($urandom), 16'($urandom), 7'($urandom));
            phase++;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (points_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("triggered_scope_capture regression: pass");
        else
            $display("triggered_scope_capture regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tsc_pkg.sv
rtl/core/tsc_ram.sv
rtl/core/tsc_front.sv
rtl/core/tsc_queue.sv
rtl/core/tsc_back.sv
rtl/core/triggered_scope_capture.sv
sim/scope_point_checker.sv
sim/tb_top.sv
